### rtl/fnv1a_128_masked_window_hash_unit_macros.svh
// ----------------------------------------------------------------------------
// fnv1a-128 hash unit assertion macros
// shared property forms for the checker, clocked on i_clk, off while i_rst_n is low but for the through-reset form
// ----------------------------------------------------------------------------
`ifndef FNV1A_128_MASKED_WINDOW_HASH_UNIT_MACROS_SVH
`define FNV1A_128_MASKED_WINDOW_HASH_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define FNVH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define FNVH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked through reset
`define FNVH_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fnvh_pkg.sv
// ----------------------------------------------------------------------------
// fnvh_pkg
// types and constants of the fnv1a-128 windowed hash unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fnvh_pkg;

    localparam int unsigned HASH_W       = 128;
    localparam int unsigned HALF_W       = 64;
    localparam int unsigned POS_W        = 32;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned WINDOW_BYTES = 16;

    localparam logic [HALF_W-1:0] BASIS_HIGH = 64'h6c62272e07bb0142;
    localparam logic [HALF_W-1:0] BASIS_LOW  = 64'h62b821756295c58d;
    localparam logic [HASH_W-1:0] BASIS      = {BASIS_HIGH, BASIS_LOW};

    localparam logic [POS_W-1:0] POS_MAX    = '1;
    localparam logic [POS_W-1:0] MASK_RESET = '1;

    // prime is 2^88 + 2^8 + 0x3b
    localparam int unsigned PRIME_SHIFT_HI = 88;
    localparam int unsigned PRIME_SHIFT_MD = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_fnvh_item;

endpackage

### rtl/fnv1a_128_masked_window_hash_unit.sv
// ----------------------------------------------------------------------------
// fnv1a_128_masked_window_hash_unit
// running fnv1a-128 hash over a byte stream with a zeroed 16-byte window
// ----------------------------------------------------------------------------
// usage
//   slave stream: one message byte per request in s_axis_tdata, s_axis_tlast
//   marks the final byte of a message
//   master stream: one request per message, the 128-bit digest in
//   m_axis_tdata, upper half in the low 64 bits
//   i_cfg_wr_en / i_cfg_wr_data write mask_start, the first byte position of
//   the zeroed window; write it only between messages
//   throughput: one byte per cycle, set by the 128-bit shift-add multiply
//   by the prime in the hash round between the input and hash registers
//   latency: digest valid one cycle after the edge that takes the last byte
//   reset: hash returns to the offset basis, position to zero, mask_start
//   to all ones, both stream sides empty
//   stall: while a digest waits on m_axis_tready, bytes keep flowing; the
//   input holds only when a second last byte meets a full output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnv1a_128_masked_window_hash_unit
    import fnvh_pkg::*;
#(
    parameter int unsigned WIN_BYTES = WINDOW_BYTES
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [POS_W-1:0]    i_cfg_wr_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [BYTE_W-1:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [HASH_W-1:0]   m_axis_tdata    // [63:0] digest_high, [127:64] digest_low
);

    t_fnvh_item        w_in_item;
    t_fnvh_item        w_masked;
    t_fnvh_item        r_s1;
    logic              r_s1_valid;
    logic              w_s1_adv;
    logic              w_accept;
    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] w_hash_next;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_data;

    assign w_in_item.data = s_axis_tdata;
    assign w_in_item.last = s_axis_tlast;

    assign w_s1_adv      = r_s1_valid && (!r_s1.last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    fnvh_window #(
        .WIN_BYTES (WIN_BYTES)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_item        (w_in_item),
        .o_item        (w_masked)
    );

    fnvh_round u_round (
        .i_hash (r_hash),
        .i_data (r_s1.data),
        .o_hash (w_hash_next)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= w_masked;
        end
    end

    // running hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= BASIS;
        end else if (w_s1_adv) begin
            r_hash <= r_s1.last ? BASIS : w_hash_next;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv && r_s1.last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1.last) begin
            r_out_data <= {w_hash_next[HALF_W-1:0], w_hash_next[HASH_W-1:HALF_W]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### rtl/fnvh_window.sv
// ----------------------------------------------------------------------------
// fnvh_window
// byte position counter and zeroed-window test on the accepted byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnvh_window
    import fnvh_pkg::*;
#(
    parameter int unsigned WIN_BYTES = WINDOW_BYTES
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [POS_W-1:0]  i_cfg_wr_data,
    input  logic              i_accept,
    input  t_fnvh_item        i_item,
    output t_fnvh_item        o_item
);

    logic [POS_W-1:0] r_mask_start;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W:0]   w_pos_ext;
    logic [POS_W:0]   w_start_ext;
    logic [POS_W:0]   w_end_ext;
    logic             w_in_window;

    assign w_pos_ext   = {1'b0, r_pos};
    assign w_start_ext = {1'b0, r_mask_start};
    assign w_end_ext   = w_start_ext + (POS_W+1)'(WIN_BYTES);
    assign w_in_window = (w_pos_ext >= w_start_ext) && (w_pos_ext < w_end_ext);

    always_comb begin
        o_item.last = i_item.last;
        o_item.data = w_in_window ? '0 : i_item.data;
    end

    always_comb begin
        n_pos = r_pos;
        if (i_accept) begin
            if (i_item.last) begin
                n_pos = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_start <= MASK_RESET;
            r_pos        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mask_start <= i_cfg_wr_data;
            end
            r_pos <= n_pos;
        end
    end

endmodule

### rtl/fnvh_round.sv
// ----------------------------------------------------------------------------
// fnvh_round
// one fnv1a step: xor byte into hash, multiply by the 128-bit prime
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnvh_round
    import fnvh_pkg::*;
(
    input  logic [HASH_W-1:0] i_hash,
    input  logic [BYTE_W-1:0] i_data,
    output logic [HASH_W-1:0] o_hash
);

    logic [HASH_W-1:0] w_mix;

    assign w_mix = {i_hash[HASH_W-1:BYTE_W], i_hash[BYTE_W-1:0] ^ i_data};

    // shift-add form of the sparse prime, 0x3b = 32 + 16 + 8 + 2 + 1
    assign o_hash = (w_mix << PRIME_SHIFT_HI) + (w_mix << PRIME_SHIFT_MD)
                  + (w_mix << 5) + (w_mix << 4) + (w_mix << 3)
                  + (w_mix << 1) + w_mix;

endmodule

### rtl/fnvh_checker.sv
// ----------------------------------------------------------------------------
// fnvh_checker
// port-level checks of the fnv1a-128 windowed hash unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fnv1a_128_masked_window_hash_unit_macros.svh"

module fnvh_checker
    import fnvh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic              s_axis_tlast,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [HASH_W-1:0] m_axis_tdata
);

    `FNVH_ASSERT_RST(a_reset_empty, !i_rst_n, !m_axis_tvalid, "digest valid after reset")

    `FNVH_ASSERT_IMP(a_no_idle_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled while output free")

    `FNVH_ASSERT_NXT(a_stall_blocks_last, !s_axis_tready, m_axis_tvalid, "input stall outlived output stall")

    `FNVH_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled digest changed")

    // a non-last byte never leads to a stall on the next cycle when output is free
    `FNVH_ASSERT_NXT(a_plain_byte_flows, s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid, s_axis_tready, "plain byte stalled the input")

endmodule

bind fnv1a_128_masked_window_hash_unit fnvh_checker u_fnvh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
